// ===== rtl/sale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sale_pkg
// shared types and codes of the sorted alarm list engine
// ----------------------------------------------------------------------------
package sale_pkg;

  localparam int NumAlarmsDef = 16;
  localparam int TickBitsDef  = 16;
  localparam int MaxRes       = 16;

  localparam logic [2:0] OpSetRel  = 3'd0;
  localparam logic [2:0] OpSetAbs  = 3'd1;
  localparam logic [2:0] OpCancel  = 3'd2;
  localparam logic [2:0] OpGetRem  = 3'd3;
  localparam logic [2:0] OpProcess = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadId    = 3'd1;
  localparam logic [2:0] StNotInUse = 3'd2;
  localparam logic [2:0] StInUse    = 3'd3;
  localparam logic [2:0] StBadValue = 3'd4;

  localparam logic [1:0] CfgMaxAllowed = 2'd0;
  localparam logic [1:0] CfgMinCycle   = 2'd1;
  localparam logic [1:0] CfgExtChecks  = 2'd2;

  // datapath commands issued by the controller
  typedef struct packed {
    logic load;        // capture input transaction
    logic decide;      // evaluate checks for set/cancel/get
    logic mod_start;   // start the modulo reduction of now + amount or reload value
    logic mod_store;   // write the reduced expiry of the node
    logic ins_start;   // start an insertion walk
    logic ins_step;    // one link of the insertion walk
    logic ins_link;    // splice the node in
    logic unlink;      // remove the current node
    logic proc_start;  // point the process walk at the head
    logic proc_fire;   // report and handle the current due alarm
    logic emit;        // put a result into the output register
    logic emit_last;
    logic emit_fired;
  } sale_cmd_t;

  // datapath status returned to the controller
  typedef struct packed {
    logic       do_insert;   // the set was accepted
    logic       do_unlink;   // the cancel was accepted
    logic       mod_done;    // modulo reduction finished
    logic       ins_done;    // insertion walk found its place
    logic       proc_due;    // current process node is due
    logic       re_arm;      // current due node is cyclic
    logic       proc_more;   // another due node follows
    logic [2:0] op;
  } sale_sts_t;

endpackage

// ===== rtl/sorted_alarm_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_alarm_list_engine
// alarm manager keeping armed alarms in an expiry-ordered linked list
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per transaction (set, cancel, get, process)
//   m_axis returns results; a process transaction may yield up to 16
//   results, the final one marked by tlast
//   cfg_we_i/cfg_idx_i/cfg_data_i write max_allowed, min_cycle and
//   extended_checks; the user writes only while the engine is idle (unchecked)
// steps from acceptance to the first result, one item at a time:
//   get and rejected operations: decide, reply; cancel: decide, unlink, reply
//   set absolute: decide, insertion walk of at most NUM_ALARMS links, splice,
//   reply; set relative first reduces now+amount modulo max_allowed+1
//   process: a result with no expiry when nothing is due; else each due alarm
//   is reported in turn, and a cyclic one is reduced and walked back into
//   the list
// reset:
//   all alarms free, list empty, registers at their defaults
// stall:
//   while m_axis_tready is low the pending result is held and the walk
//   waits; s_axis_tready stays low until the item is finished
// ----------------------------------------------------------------------------
module sorted_alarm_list_engine #(
  parameter int NUM_ALARMS = sale_pkg::NumAlarmsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], alarm_id[10:3], tick_amount[26:11], cycle_length[42:27],
  // counter_now[58:43]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], remaining_ticks[18:3], fired[19], expired_alarm[23:20]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import sale_pkg::*;

  logic [15:0] max_allowed_q, min_cycle_q;
  logic        ext_q;
  logic        ovalid_q;
  sale_cmd_t   cmd;
  sale_sts_t   sts;
  logic [2:0]  st;
  logic [15:0] rem;
  logic        fired, last;
  logic [3:0]  exp_id;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_allowed_q <= 16'hFFFF;
      min_cycle_q   <= 16'd1;
      ext_q         <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxAllowed: max_allowed_q <= cfg_data_i;
        CfgMinCycle:   min_cycle_q   <= cfg_data_i;
        CfgExtChecks:  ext_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.emit) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  sale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (!ovalid_q || m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sale_dp #(.NumAlarms(NUM_ALARMS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (s_axis_tdata[2:0]),
    .alarm_id_i     (s_axis_tdata[10:3]),
    .tick_amount_i  (s_axis_tdata[26:11]),
    .cycle_length_i (s_axis_tdata[42:27]),
    .counter_now_i  (s_axis_tdata[58:43]),
    .max_allowed_i  (max_allowed_q),
    .min_cycle_i    (min_cycle_q),
    .ext_checks_i   (ext_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (st),
    .remaining_o    (rem),
    .fired_o        (fired),
    .expired_o      (exp_id),
    .last_o         (last)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {exp_id, fired, rem, st};
  assign m_axis_tlast  = last;

`ifndef SYNTH
  // a result waiting is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |-> !cmd.emit)
    else $error("result overwritten while stalled");
  // a result that reports no expiry always closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && !cmd.emit_fired |-> cmd.emit_last)
    else $error("plain result without tlast");
  // reported alarm id lies within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[19] |-> 32'(m_axis_tdata[23:20]) < NUM_ALARMS)
    else $error("expired id out of range");
`endif

endmodule

// ===== rtl/sale_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sale_ctrl
// sequencer for decode, list walks and result hand-off
// ----------------------------------------------------------------------------
module sale_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  input  sale_pkg::sale_sts_t sts_i,
  output sale_pkg::sale_cmd_t cmd_o
);
  import sale_pkg::*;

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SDecide  = 4'd1;
  localparam logic [3:0] SInsWalk = 4'd2;
  localparam logic [3:0] SInsLink = 4'd3;
  localparam logic [3:0] SReply   = 4'd4;
  localparam logic [3:0] SPHead   = 4'd5;
  localparam logic [3:0] SPCheck  = 4'd6;
  localparam logic [3:0] SPFire   = 4'd7;
  localparam logic [3:0] SPWalk   = 4'd8;
  localparam logic [3:0] SMod     = 4'd9;
  localparam logic [3:0] SUnlink  = 4'd10;
  localparam logic [3:0] SPNone   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       proc_q, proc_d;
  logic       fired_any_q, fired_any_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      proc_q      <= 1'b0;
      fired_any_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      proc_q      <= proc_d;
      fired_any_q <= fired_any_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d     = state_q;
    proc_d      = proc_q;
    fired_any_d = fired_any_q;
    cmd_o       = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDecide;
        end
      end
      SDecide: begin
        if (sts_i.op == OpProcess) begin
          proc_d          = 1'b1;
          fired_any_d     = 1'b0;
          cmd_o.proc_start = 1'b1;
          state_d         = SPCheck;
        end else begin
          proc_d       = 1'b0;
          cmd_o.decide = 1'b1;
          if (sts_i.do_insert) begin
            if (sts_i.op == OpSetRel) begin
              cmd_o.mod_start = 1'b1;
              state_d         = SMod;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = SInsWalk;
            end
          end else if (sts_i.do_unlink) begin
            state_d = SUnlink;
          end else begin
            state_d = SReply;
          end
        end
      end
      SMod: begin
        if (sts_i.mod_done) begin
          cmd_o.mod_store = 1'b1;
          cmd_o.ins_start = 1'b1;
          state_d         = SInsWalk;
        end
      end
      SUnlink: begin
        cmd_o.unlink = 1'b1;
        state_d      = SReply;
      end
      SInsWalk: begin
        if (sts_i.ins_done) state_d = SInsLink;
        else cmd_o.ins_step = 1'b1;
      end
      SInsLink: begin
        cmd_o.ins_link = 1'b1;
        state_d        = proc_q ? SPWalk : SReply;
      end
      SReply: begin
        if (out_free_i) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = SIdle;
        end
      end
      SPCheck: begin
        if (sts_i.proc_due) state_d = SPFire;
        else state_d = fired_any_q ? SIdle : SPNone;
      end
      SPFire: begin
        if (out_free_i) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_fired = 1'b1;
          cmd_o.emit_last  = !sts_i.proc_more;
          cmd_o.proc_fire  = 1'b1;
          fired_any_d      = 1'b1;
          if (sts_i.re_arm) begin
            cmd_o.mod_start = 1'b1;
            state_d         = SMod;
          end else begin
            state_d = SPWalk;
          end
        end
      end
      SPWalk: begin
        state_d = SPHead;
      end
      SPHead: begin
        state_d = SPCheck;
      end
      SPNone: begin
        if (out_free_i) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// ===== rtl/sale_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sale_dp
// alarm tables, sorted list walks and result formation
// ----------------------------------------------------------------------------
module sale_dp #(
  parameter int NumAlarms = sale_pkg::NumAlarmsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          op_i,
  input  logic [7:0]          alarm_id_i,
  input  logic [15:0]         tick_amount_i,
  input  logic [15:0]         cycle_length_i,
  input  logic [15:0]         counter_now_i,
  input  logic [15:0]         max_allowed_i,
  input  logic [15:0]         min_cycle_i,
  input  logic                ext_checks_i,
  input  sale_pkg::sale_cmd_t cmd_i,
  output sale_pkg::sale_sts_t sts_o,
  output logic [2:0]          status_o,
  output logic [15:0]         remaining_o,
  output logic                fired_o,
  output logic [3:0]          expired_o,
  output logic                last_o
);
  import sale_pkg::*;

  localparam int TickBits = TickBitsDef;
  localparam int IdW  = (NumAlarms > 1) ? $clog2(NumAlarms) : 1;
  localparam int PtrW = IdW + 1;   // msb set means no alarm
  localparam int CntW = $clog2(NumAlarms + 1);
  localparam int ResW = $clog2(MaxRes + 1);

  logic [TickBits-1:0] expiry_q [NumAlarms];
  logic [TickBits-1:0] reload_q [NumAlarms];
  logic [PtrW-1:0]     next_q   [NumAlarms];
  logic [PtrW-1:0]     prev_q   [NumAlarms];
  logic [NumAlarms-1:0] in_use_q;
  logic [PtrW-1:0]     head_q;

  logic [2:0]          op_q;
  logic [7:0]          aid_q;
  logic [15:0]         amt_q, cyc_q, now_q;
  logic [PtrW-1:0]     node_q;            // node being inserted
  logic [PtrW-1:0]     bef_q, aft_q;
  logic                wrap_q;            // skip phase of the insertion walk
  logic [CntW-1:0]     guard_q;
  logic [PtrW-1:0]     cur_q;             // process walk
  logic [CntW-1:0]     visited_q;
  logic [ResW-1:0]     nres_q;
  logic [2:0]          st_q;
  logic [15:0]         rem_q;

  function automatic logic ok(input logic [PtrW-1:0] p);
    ok = !p[PtrW-1];
  endfunction

  localparam logic [PtrW-1:0] NoAlarm = {1'b1, {IdW{1'b0}}};

  // checks for the addressed alarm
  logic        id_ok, used, rng_bad;
  logic [IdW-1:0] aidx;
  logic [16:0] rem_w;
  assign aidx  = aid_q[IdW-1:0];
  assign id_ok = ({24'd0, aid_q} < 32'(NumAlarms));
  assign used  = id_ok && in_use_q[aidx];
  assign rng_bad = (amt_q > max_allowed_i) || (cyc_q > max_allowed_i) ||
                   ((cyc_q != 16'd0) && (cyc_q < min_cycle_i));

  // (now + amount or reload) mod (max + 1) by restoring remainder, one trial
  // subtraction of the shifted modulus per cycle
  logic [16:0] mod1;
  logic [16:0] mod_sum;
  logic [15:0] addend;
  logic [16:0] mrem_q;
  logic [32:0] mdiv_q;
  logic [4:0]  mcnt_q;
  logic [TickBits-1:0] mod_res;
  assign addend  = (op_q == OpProcess) ? 16'(reload_q[cur_q[IdW-1:0]]) : amt_q;
  assign mod1    = {1'b0, max_allowed_i} + 17'd1;
  assign mod_sum = {1'b0, now_q} + {1'b0, addend};
  assign mod_res = TickBits'(mrem_q[15:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (cmd_i.mod_start) begin
      mcnt_q <= 5'd17;
    end else if (mcnt_q != '0) begin
      mcnt_q <= mcnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      mrem_q <= mod_sum;
      mdiv_q <= {mod1, 16'd0};
    end else if (mcnt_q != '0) begin
      if ({16'd0, mrem_q} >= mdiv_q) mrem_q <= mrem_q - mdiv_q[16:0];
      mdiv_q <= {1'b0, mdiv_q[32:1]};
    end
  end

  // insertion walk compare
  logic [TickBits-1:0] val_w, aft_val;
  logic                aft_ok;
  assign val_w   = expiry_q[node_q[IdW-1:0]];
  assign aft_ok  = ok(aft_q) && (guard_q < CntW'(NumAlarms));
  assign aft_val = expiry_q[aft_q[IdW-1:0]];
  logic step_wrap, step_cmp;
  // skip phase applies only when the new value lies below now
  assign step_wrap = wrap_q && (val_w < TickBits'(now_q)) && aft_ok &&
                     (aft_val > TickBits'(now_q));
  assign step_cmp  = aft_ok && (aft_val < val_w);

  // process walk
  logic cur_due;
  logic [PtrW-1:0] cur_nx;
  assign cur_nx  = next_q[cur_q[IdW-1:0]];
  assign cur_due = ok(cur_q) && (visited_q < CntW'(NumAlarms)) &&
                   (nres_q < ResW'(MaxRes)) &&
                   (expiry_q[cur_q[IdW-1:0]] == TickBits'(now_q));

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.do_insert = (op_q == OpSetRel || op_q == OpSetAbs) && id_ok &&
                      !(op_q == OpSetRel && amt_q == 16'd0) && !used &&
                      !(ext_checks_i && rng_bad);
    sts_o.do_unlink = (op_q == OpCancel) && used;
    sts_o.mod_done  = (mcnt_q == '0);
    sts_o.ins_done  = !step_wrap && !step_cmp;
    sts_o.proc_due  = cur_due;
    sts_o.re_arm    = reload_q[cur_q[IdW-1:0]] != '0;
    // the walk goes on to the old successor, whose expiry a re-arm leaves alone
    sts_o.proc_more = ok(cur_nx) && (visited_q + CntW'(1) < CntW'(NumAlarms)) &&
                      (nres_q + ResW'(1) < ResW'(MaxRes)) &&
                      (expiry_q[cur_nx[IdW-1:0]] == TickBits'(now_q));
  end

  assign rem_w = ({1'b0, expiry_q[aidx][15:0]} > {1'b0, now_q}) ?
                 {1'b0, expiry_q[aidx][15:0]} - {1'b0, now_q} :
                 {1'b0, max_allowed_i} + {1'b0, expiry_q[aidx][15:0]} -
                 {1'b0, now_q};

  logic [PtrW-1:0] rm_id;
  assign rm_id = (op_q == OpProcess) ? cur_q : {1'b0, aidx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      head_q   <= NoAlarm;
    end else begin
      if (cmd_i.decide && sts_o.do_insert) in_use_q[aidx] <= 1'b1;
      if (cmd_i.unlink) in_use_q[aidx] <= 1'b0;
      if (cmd_i.proc_fire && !sts_o.re_arm) in_use_q[cur_q[IdW-1:0]] <= 1'b0;
      if (cmd_i.unlink || cmd_i.proc_fire) begin
        if (!ok(prev_q[rm_id[IdW-1:0]]))
          head_q <= ok(next_q[rm_id[IdW-1:0]]) ? next_q[rm_id[IdW-1:0]] : NoAlarm;
      end
      if (cmd_i.ins_link && !ok(bef_q)) head_q <= node_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      aid_q <= alarm_id_i;
      amt_q <= tick_amount_i;
      cyc_q <= cycle_length_i;
      now_q <= counter_now_i;
    end
    if (cmd_i.decide) begin
      rem_q <= 16'd0;
      if (op_q > OpProcess) st_q <= StBadValue;
      else if (!id_ok) st_q <= StBadId;
      else if (op_q == OpSetRel || op_q == OpSetAbs) begin
        if (op_q == OpSetRel && amt_q == 16'd0) st_q <= StBadValue;
        else if (used) st_q <= StInUse;
        else if (ext_checks_i && rng_bad) st_q <= StBadValue;
        else begin
          st_q            <= StOk;
          reload_q[aidx]  <= TickBits'(cyc_q);
          // a relative expiry is written later from the modulo unit
          expiry_q[aidx]  <= TickBits'(amt_q);
          node_q          <= {1'b0, aidx};
        end
      end else if (!used) st_q <= StNotInUse;
      else begin
        st_q <= StOk;
        if (op_q == OpGetRem) rem_q <= rem_w[15:0];
      end
    end
    if (cmd_i.mod_store) expiry_q[node_q[IdW-1:0]] <= mod_res;
    if (cmd_i.unlink || cmd_i.proc_fire) begin
      if (ok(prev_q[rm_id[IdW-1:0]]))
        next_q[prev_q[rm_id[IdW-1:0]][IdW-1:0]] <= next_q[rm_id[IdW-1:0]];
      if (ok(next_q[rm_id[IdW-1:0]]))
        prev_q[next_q[rm_id[IdW-1:0]][IdW-1:0]] <= prev_q[rm_id[IdW-1:0]];
    end
    if (cmd_i.proc_start) begin
      cur_q     <= head_q;
      visited_q <= '0;
      nres_q    <= '0;
    end
    if (cmd_i.proc_fire) begin
      visited_q <= visited_q + CntW'(1);
      nres_q    <= nres_q + ResW'(1);
      cur_q     <= cur_nx;
      if (sts_o.re_arm) node_q <= cur_q;
    end
    if (cmd_i.ins_start) begin
      bef_q   <= NoAlarm;
      aft_q   <= head_q;
      guard_q <= '0;
      wrap_q  <= 1'b1;
    end
    if (cmd_i.ins_step) begin
      if (step_wrap || step_cmp) begin
        bef_q   <= aft_q;
        aft_q   <= next_q[aft_q[IdW-1:0]];
        guard_q <= guard_q + CntW'(1);
      end
      if (!step_wrap) wrap_q <= 1'b0;
    end
    if (cmd_i.ins_link) begin
      next_q[node_q[IdW-1:0]] <= ok(aft_q) ? aft_q : NoAlarm;
      prev_q[node_q[IdW-1:0]] <= bef_q;
      if (ok(bef_q)) next_q[bef_q[IdW-1:0]] <= node_q;
      if (ok(aft_q)) prev_q[aft_q[IdW-1:0]] <= node_q;
    end
    if (cmd_i.emit) begin
      status_o    <= cmd_i.emit_fired ? StOk : ((op_q == OpProcess) ? StOk : st_q);
      remaining_o <= (cmd_i.emit_fired || op_q == OpProcess) ? 16'd0 : rem_q;
      fired_o     <= cmd_i.emit_fired;
      expired_o   <= cmd_i.emit_fired ? 4'(cur_q[IdW-1:0]) : 4'd0;
      last_o      <= cmd_i.emit_last;
    end
  end

endmodule
